// File: rtl/bmft_pkg.sv
package bmft_pkg;

    typedef logic [2:0] cmd_code_t;

    localparam cmd_code_t CMD_READ     = 3'd0;
    localparam cmd_code_t CMD_SECTOR   = 3'd1;
    localparam cmd_code_t CMD_TAG      = 3'd2;
    localparam cmd_code_t CMD_BUFFER   = 3'd3;
    localparam cmd_code_t CMD_ERASE    = 3'd4;
    localparam cmd_code_t CMD_COPY     = 3'd5;
    localparam cmd_code_t CMD_UNMAPPED = 3'd6;

    localparam int ADDR_W = 6;
    localparam int TAG_W  = 6;
    localparam int SLOT_W = 2;

    // lsn / pages computed as (lsn * RECIP) >> RECIP_SHIFT, exact for 6-bit lsn
    localparam int RECIP_SHIFT = 12;
    localparam int PROD_W      = 18;

    typedef struct packed {
        logic      load;
        logic      decode;
        logic      cnt_clr;
        logic      cnt_inc;
        logic      emit;
        cmd_code_t code;
        logic      last;
        logic      map_set;
        logic      used_set;
        logic      swap;
    } ctrl_cmd_t;

    typedef struct packed {
        logic write;
        logic in_range;
        logic mapped;
        logic used;
        logic cnt_last;
        logic cnt_is_off;
        logic out_free;
    } ctrl_sts_t;

endpackage

// File: rtl/bmft_ifs.sv
interface bmft_req_if;
    logic       valid;
    logic       ready;
    logic       action;
    logic [5:0] logical_sector;

    modport source (output valid, output action, output logical_sector, input ready);
    modport sink   (input valid, input action, input logical_sector, output ready);
endinterface

interface bmft_op_if;
    logic       valid;
    logic       ready;
    logic [2:0] command;
    logic [5:0] page_address;
    logic [5:0] tag_value;
    logic [1:0] buffer_slot;
    logic       last;

    modport source (output valid, output command, output page_address, output tag_value,
                    output buffer_slot, output last, input ready);
    modport sink   (input valid, input command, input page_address, input tag_value,
                    input buffer_slot, input last, output ready);
endinterface

// File: rtl/bmft_datapath.sv
module bmft_datapath
    import bmft_pkg::*;
#(
    parameter int PAGES_IN_BLOCK = 4,
    parameter int DATA_BLOCKS    = 15
)
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_action,
    input  logic [5:0]        in_lsn,
    input  ctrl_cmd_t         c,
    output ctrl_sts_t         s,
    output logic              out_valid,
    input  logic              out_ready,
    output cmd_code_t         out_command,
    output logic [ADDR_W-1:0] out_page_address,
    output logic [TAG_W-1:0]  out_tag_value,
    output logic [SLOT_W-1:0] out_buffer_slot,
    output logic              out_last
);

    localparam int OFF_W     = $clog2(PAGES_IN_BLOCK);
    localparam int PBN_W     = $clog2(DATA_BLOCKS + 1);
    localparam int LBN_SPAN  = 63 / PAGES_IN_BLOCK + 1;
    localparam int MAP_DEPTH = (DATA_BLOCKS < LBN_SPAN) ? DATA_BLOCKS : LBN_SPAN;
    localparam int MAP_IDX_W = (MAP_DEPTH > 1) ? $clog2(MAP_DEPTH) : 1;
    localparam int RECIP     = ((1 << RECIP_SHIFT) + PAGES_IN_BLOCK - 1) / PAGES_IN_BLOCK;
    localparam int FULL_W    = PBN_W + 7;
    localparam logic [TAG_W-1:0] FREE_TAG = TAG_W'(DATA_BLOCKS % 64);

    logic                      action_reg;
    logic [5:0]                lsn_reg;
    logic [5:0]                lbn_reg;
    logic [OFF_W-1:0]          off_reg;
    logic [OFF_W-1:0]          cnt_reg;
    logic [MAP_DEPTH-1:0]      map_valid_reg;
    logic [PBN_W-1:0]          map_pbn_reg [MAP_DEPTH];
    logic [PAGES_IN_BLOCK-1:0] used_reg [MAP_DEPTH];
    logic [PBN_W-1:0]          free_reg;

    logic                      out_valid_reg;
    cmd_code_t                 out_command_reg;
    logic [ADDR_W-1:0]         out_addr_reg;
    logic [TAG_W-1:0]          out_tag_reg;
    logic [SLOT_W-1:0]         out_slot_reg;
    logic                      out_last_reg;

    logic [ADDR_W-1:0]         addr_next;
    logic [TAG_W-1:0]          tag_next;
    logic [SLOT_W-1:0]         slot_next;

    logic [PROD_W-1:0]         prod;
    logic [5:0]                lbn_calc;
    logic [OFF_W-1:0]          off_calc;
    logic [MAP_IDX_W-1:0]      idx;
    logic                      in_range;
    logic                      mapped;
    logic [PBN_W-1:0]          cur_pbn;
    logic [PBN_W-1:0]          first_pbn;
    logic [PBN_W-1:0]          pbn_sel;
    logic [OFF_W-1:0]          page_sel;
    logic [FULL_W-1:0]         full_addr;
    logic                      out_free;

    assign prod     = PROD_W'(lsn_reg) * PROD_W'(RECIP);
    assign lbn_calc = prod[PROD_W-1:RECIP_SHIFT];
    assign off_calc = OFF_W'(lsn_reg - 6'(12'(lbn_calc) * 12'(PAGES_IN_BLOCK)));

    assign idx       = lbn_reg[MAP_IDX_W-1:0];
    assign in_range  = 16'(lbn_reg) < 16'(DATA_BLOCKS);
    assign mapped    = in_range && map_valid_reg[idx];
    assign cur_pbn   = map_pbn_reg[idx];
    assign first_pbn = PBN_W'(DATA_BLOCKS) - PBN_W'(lbn_reg);
    assign out_free  = !out_valid_reg || out_ready;

    assign s.write      = action_reg;
    assign s.in_range   = in_range;
    assign s.mapped     = mapped;
    assign s.used       = mapped && used_reg[idx][off_reg];
    assign s.cnt_last   = cnt_reg == OFF_W'(PAGES_IN_BLOCK - 1);
    assign s.cnt_is_off = cnt_reg == off_reg;
    assign s.out_free   = out_free;

    always_comb
    begin
        pbn_sel  = (c.code == CMD_TAG && !mapped) ? first_pbn : cur_pbn;
        page_sel = '0;
        if (c.code == CMD_BUFFER || c.code == CMD_COPY)
        begin
            page_sel = cnt_reg;
        end
        else if (c.code == CMD_READ || c.code == CMD_SECTOR)
        begin
            page_sel = off_reg;
        end
        full_addr = FULL_W'(pbn_sel) * FULL_W'(PAGES_IN_BLOCK) + FULL_W'(page_sel);
    end

    always_comb
    begin
        addr_next = '0;
        tag_next  = '0;
        slot_next = '0;
        unique case (c.code)
            CMD_READ:
            begin
                addr_next = full_addr[ADDR_W-1:0];
            end
            CMD_SECTOR:
            begin
                addr_next = full_addr[ADDR_W-1:0];
                tag_next  = lsn_reg;
            end
            CMD_TAG:
            begin
                addr_next = full_addr[ADDR_W-1:0];
                tag_next  = mapped ? FREE_TAG : lbn_reg;
            end
            CMD_BUFFER:
            begin
                addr_next = full_addr[ADDR_W-1:0];
                slot_next = SLOT_W'(cnt_reg);
            end
            CMD_ERASE:
            begin
                addr_next = full_addr[ADDR_W-1:0];
                addr_next = ADDR_W'(cur_pbn);
            end
            CMD_COPY:
            begin
                addr_next = full_addr[ADDR_W-1:0];
                tag_next  = (cnt_reg == off_reg) ? lsn_reg : '0;
                slot_next = SLOT_W'(cnt_reg);
            end
            default:
            begin
                addr_next = '0;
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (c.load)
        begin
            action_reg <= in_action;
            lsn_reg    <= in_lsn;
        end
        if (c.decode)
        begin
            lbn_reg <= lbn_calc;
            off_reg <= off_calc;
        end
        if (c.map_set)
        begin
            map_pbn_reg[idx] <= first_pbn;
        end
        else if (c.swap)
        begin
            map_pbn_reg[idx] <= free_reg;
        end
        if (c.emit)
        begin
            out_command_reg <= c.code;
            out_addr_reg    <= addr_next;
            out_tag_reg     <= tag_next;
            out_slot_reg    <= slot_next;
            out_last_reg    <= c.last;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg       <= '0;
            map_valid_reg <= '0;
            free_reg      <= '0;
            out_valid_reg <= 1'b0;
            for (int i = 0; i < MAP_DEPTH; i++)
            begin
                used_reg[i] <= '0;
            end
        end
        else
        begin
            if (c.cnt_clr)
            begin
                cnt_reg <= '0;
            end
            else if (c.cnt_inc)
            begin
                cnt_reg <= cnt_reg + OFF_W'(1);
            end
            if (c.map_set)
            begin
                map_valid_reg[idx] <= 1'b1;
            end
            if (c.swap)
            begin
                free_reg <= cur_pbn;
            end
            if (c.used_set)
            begin
                used_reg[idx][off_reg] <= 1'b1;
            end
            if (c.emit)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    assign out_valid        = out_valid_reg;
    assign out_command      = out_command_reg;
    assign out_page_address = out_addr_reg;
    assign out_tag_value    = out_tag_reg;
    assign out_buffer_slot  = out_slot_reg;
    assign out_last         = out_last_reg;

    a_swap_frees_old: assert property (@(posedge clk) disable iff (!rst_n)
        c.swap |=> free_reg == $past(cur_pbn))
        else $error("free block does not hold the old block after swap");

    a_map_set_fresh: assert property (@(posedge clk) disable iff (!rst_n)
        c.map_set |-> (in_range && !mapped))
        else $error("map set on a mapped or out of range block");

endmodule

// File: rtl/bmft_ctrl.sv
module bmft_ctrl
    import bmft_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      in_valid,
    output logic      in_ready,
    output ctrl_cmd_t c,
    input  ctrl_sts_t s
);

    localparam logic [2:0] S_IDLE     = 3'd0;
    localparam logic [2:0] S_DECODE   = 3'd1;
    localparam logic [2:0] S_DISPATCH = 3'd2;
    localparam logic [2:0] S_SECTOR   = 3'd3;
    localparam logic [2:0] S_BUF      = 3'd4;
    localparam logic [2:0] S_ERASE    = 3'd5;
    localparam logic [2:0] S_FREE     = 3'd6;
    localparam logic [2:0] S_COPY     = 3'd7;

    logic [2:0] state_reg;
    logic [2:0] state_next;

    assign in_ready = state_reg == S_IDLE;

    always_comb
    begin
        c          = '0;
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    c.load     = 1'b1;
                    state_next = S_DECODE;
                end
            end
            S_DECODE:
            begin
                c.decode   = 1'b1;
                c.cnt_clr  = 1'b1;
                state_next = S_DISPATCH;
            end
            S_DISPATCH:
            begin
                priority if (!s.write)
                begin
                    if (s.out_free)
                    begin
                        c.emit     = 1'b1;
                        c.code     = s.mapped ? CMD_READ : CMD_UNMAPPED;
                        c.last     = 1'b1;
                        state_next = S_IDLE;
                    end
                end
                else if (!s.in_range)
                begin
                    state_next = S_IDLE;
                end
                else if (!s.mapped)
                begin
                    if (s.out_free)
                    begin
                        c.emit     = 1'b1;
                        c.code     = CMD_TAG;
                        c.map_set  = 1'b1;
                        state_next = S_SECTOR;
                    end
                end
                else if (!s.used)
                begin
                    state_next = S_SECTOR;
                end
                else
                begin
                    state_next = S_BUF;
                end
            end
            S_SECTOR:
            begin
                if (s.out_free)
                begin
                    c.emit     = 1'b1;
                    c.code     = CMD_SECTOR;
                    c.last     = 1'b1;
                    c.used_set = 1'b1;
                    state_next = S_IDLE;
                end
            end
            S_BUF:
            begin
                if (s.cnt_is_off || s.out_free)
                begin
                    c.emit = !s.cnt_is_off;
                    c.code = CMD_BUFFER;
                    if (s.cnt_last)
                    begin
                        c.cnt_clr  = 1'b1;
                        state_next = S_ERASE;
                    end
                    else
                    begin
                        c.cnt_inc = 1'b1;
                    end
                end
            end
            S_ERASE:
            begin
                if (s.out_free)
                begin
                    c.emit     = 1'b1;
                    c.code     = CMD_ERASE;
                    state_next = S_FREE;
                end
            end
            S_FREE:
            begin
                if (s.out_free)
                begin
                    c.emit     = 1'b1;
                    c.code     = CMD_TAG;
                    c.swap     = 1'b1;
                    state_next = S_COPY;
                end
            end
            S_COPY:
            begin
                if (s.out_free)
                begin
                    c.emit = 1'b1;
                    c.code = CMD_COPY;
                    c.last = s.cnt_last;
                    if (s.cnt_last)
                    begin
                        state_next = S_IDLE;
                    end
                    else
                    begin
                        c.cnt_inc = 1'b1;
                    end
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    a_emit_has_room: assert property (@(posedge clk) disable iff (!rst_n)
        c.emit |-> s.out_free)
        else $error("beat issued while output register is full");

    a_accept_decodes: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && in_ready) |=> state_reg == S_DECODE)
        else $error("accepted request not decoded");

    a_last_ends_run: assert property (@(posedge clk) disable iff (!rst_n)
        (c.emit && c.last) |=> state_reg == S_IDLE)
        else $error("run did not end after last beat");

endmodule

// File: rtl/block_mapped_flash_translation.sv
// First command beat: registered from S_DISPATCH for a read or a first write, from S_SECTOR
// for a write to a fresh page of a mapped block, from S_BUF for a rewrite; an out of range
// write is ignored. Up to one beat per cycle from the single output register while op.ready
// holds; a new request is taken only in S_IDLE, after the run ends. A rewrite runs longest,
// as its page walk visits every page in S_BUF and again in S_COPY.
// Reset: block map unmapped, page marks cleared, free block 0, all at once; no clearing pass.
module block_mapped_flash_translation
    import bmft_pkg::*;
#(
    parameter int PAGES_IN_BLOCK = 4,
    parameter int DATA_BLOCKS    = 15
)
(
    input  logic  clk,
    input  logic  rst_n,
    bmft_req_if.sink  req,
    bmft_op_if.source op
);

    ctrl_cmd_t c;
    ctrl_sts_t s;
    logic      in_ready;

    assign req.ready = in_ready;

    bmft_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (req.valid),
        .in_ready (in_ready),
        .c        (c),
        .s        (s)
    );

    bmft_datapath #(
        .PAGES_IN_BLOCK (PAGES_IN_BLOCK),
        .DATA_BLOCKS    (DATA_BLOCKS)
    ) u_datapath (
        .clk              (clk),
        .rst_n            (rst_n),
        .in_action        (req.action),
        .in_lsn           (req.logical_sector),
        .c                (c),
        .s                (s),
        .out_valid        (op.valid),
        .out_ready        (op.ready),
        .out_command      (op.command),
        .out_page_address (op.page_address),
        .out_tag_value    (op.tag_value),
        .out_buffer_slot  (op.buffer_slot),
        .out_last         (op.last)
    );

endmodule
